### src/animation_time_mapper_defines.svh
// Assertion macros for the animation time mapper.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef ANIMATION_TIME_MAPPER_DEFINES_SVH
`define ANIMATION_TIME_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// ante |-> cons, checked out of reset
`define ATM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// ante |=> cons, checked out of reset
`define ATM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATM_ASSERT_IMP(label, ante, cons, msg)
`define ATM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### src/atm_pkg.sv
// Shared types and constants of the animation time mapper.
// No dependencies; imported by every module of the block.
package atm_pkg;

  localparam int RATE_BITS = 32;
  localparam int RATE_FRAC = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [RATE_BITS-1:0] RATE_ONE = RATE_BITS'(1) << RATE_FRAC;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_CLAMP = 2'd1,
    MODE_WRAP  = 2'd2,
    MODE_CYCLE = 2'd3
  } repeat_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_REPEAT_MODE  = 3'd0,
    CFG_MIN_TIME     = 3'd1,
    CFG_MAX_TIME     = 3'd2,
    CFG_PHASE_OFFSET = 3'd3,
    CFG_RATE_SCALE   = 3'd4,
    CFG_RUN_ENABLE   = 3'd5
  } cfg_index_e;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### src/animation_time_mapper.sv
// Top level of the animation time mapper: config registers, sequencer, output register.
// Depends on atm_pkg, atm_mul, atm_div and animation_time_mapper_defines.svh.
//
// Usage: one system_time_i sample per frame enters on the input channel
// (in_valid_i, accepted when in_stall_o is low). Each sample yields exactly one
// result transaction on the output channel (out_valid_o, taken when out_stall_i
// is low). Registers are written over the cfg channel (cfg_ready_o is always
// high); write them only while the block is idle, which the block does not enforce.
// The block takes one sample at a time. The two bit-serial products
// (interval * rate and local time * rate) run for every enabled sample; modes
// none and clamp need nothing more, nor do wrap and cycle over an empty window.
// Otherwise wrap and cycle add the bit-serial divider, one quotient bit per
// cycle over TIME_BITS+18 numerator bits.
// A sample taken while disabled skips the arithmetic and goes straight to its result.
// Reset: registers take their defaults (rate 1.0, enabled, mode none) and
// playback is not started; the next enabled sample latches the start time.
// Stall: a finished result waits in the output register; the core takes the
// next sample meanwhile and holds its own result until the register frees.
`include "animation_time_mapper_defines.svh"

module animation_time_mapper
  import atm_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [TIME_BITS-1:0]        system_time_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [TIME_BITS-1:0]        anim_time_o,
  output logic [TIME_BITS-2:0]        frame_interval_o,
  output logic [TIME_BITS-1:0]        anim_interval_o,
  output logic [TIME_BITS-2:0]        elapsed_total_o,
  output logic                        first_frame_o,
  output logic                        active_o,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [((TIME_BITS > RATE_BITS) ? TIME_BITS : RATE_BITS)-1:0] cfg_data_i
);

  localparam int TB  = TIME_BITS;
  localparam int PW  = TB + RATE_BITS;   // full product
  localparam int TW  = PW - RATE_FRAC;   // product after dropping rate fraction
  localparam int TTW = TW + 1;           // scaled time plus phase
  localparam int NW  = TW + 2;           // offset from min, divider numerator

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DIFF   = 12'b0000_0000_0010,
    S_ABS    = 12'b0000_0000_0100,
    S_SUM    = 12'b0000_0000_1000,
    S_MUL_IV = 12'b0000_0001_0000,
    S_MUL_T  = 12'b0000_0010_0000,
    S_MAP    = 12'b0000_0100_0000,
    S_NABS   = 12'b0000_1000_0000,
    S_DIV    = 12'b0001_0000_0000,
    S_FIX    = 12'b0010_0000_0000,
    S_FIN    = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  // configuration
  repeat_mode_e         mode_q;
  logic [TB-1:0]        min_q, max_q, phase_q;
  logic [RATE_BITS-1:0] rate_q;
  logic                 run_q;

  // playback state
  state_e        state_q, state_d;
  logic          started_q, started_d;
  logic [TB-1:0] stamp_q, stamp_d;
  logic [TB-1:0] prev_q, prev_d;
  logic [TB-2:0] sum_q, sum_d;

  // per-sample working registers
  logic [TB-1:0]  local_q, local_d;
  logic [TB:0]    d_q, d_d;
  logic [TB-2:0]  ival_q, ival_d;
  logic [TB-1:0]  aival_q, aival_d;
  logic [TTW-1:0] t_q, t_d;
  logic [TB-1:0]  range_q, range_d;
  logic [NW-1:0]  n_q, n_d;
  logic           nneg_q, nneg_d;
  logic [TB-1:0]  r_q, r_d;
  logic           odd_q, odd_d;
  logic [TB-1:0]  anim_q, anim_d;
  logic           first_q, first_d;
  logic           active_q, active_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [TB-1:0] o_anim_q, o_aival_q;
  logic [TB-2:0] o_ival_q, o_sum_q;
  logic          o_first_q, o_active_q;

  logic in_accept;
  logic out_load;

  // arithmetic units
  logic [TB-1:0] mul_a;
  logic          mul_start;
  logic [PW-1:0] prod;
  unit_stat_t    mul_stat;
  logic          div_start;
  logic [NW-1:0] nmag;
  logic [TB-1:0] div_rem;
  logic          div_q_lsb;
  unit_stat_t    div_stat;

  // datapath terms
  logic [TB-1:0]  start_sel;
  logic [TB:0]    loc_diff;
  logic [TB-1:0]  loc_sat;
  logic [TB:0]    abs_d;
  logic [TB-2:0]  ival_sat;
  logic [TB-1:0]  sum_ext;
  logic [TB-2:0]  sum_sat;
  logic [TW-1:0]  tw;
  logic [TB-1:0]  tw_sat;
  logic [TTW-1:0] t_sum;
  logic [TB-1:0]  t_sat;
  logic [TTW-1:0] min_t, max_t;
  logic [TB:0]    range_full;
  logic           range_empty;
  logic [NW-1:0]  n_sub;
  logic           rem_nz;

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      min_q   <= '0;
      max_q   <= '0;
      phase_q <= '0;
      rate_q  <= RATE_ONE;
      run_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_REPEAT_MODE:  mode_q  <= repeat_mode_e'(cfg_data_i[1:0]);
        CFG_MIN_TIME:     min_q   <= cfg_data_i[TB-1:0];
        CFG_MAX_TIME:     max_q   <= cfg_data_i[TB-1:0];
        CFG_PHASE_OFFSET: phase_q <= cfg_data_i[TB-1:0];
        CFG_RATE_SCALE:   rate_q  <= cfg_data_i[RATE_BITS-1:0];
        CFG_RUN_ENABLE:   run_q   <= cfg_data_i[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath terms, one add or compare per stage
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // local time: sample minus start, saturated to the signed range
  assign start_sel = started_q ? stamp_q : system_time_i;
  assign loc_diff  = {system_time_i[TB-1], system_time_i} - {start_sel[TB-1], start_sel};
  assign loc_sat   = (loc_diff[TB] != loc_diff[TB-1]) ?
                     {loc_diff[TB], {(TB-1){~loc_diff[TB]}}} : loc_diff[TB-1:0];

  // absolute interval, saturated to the positive range
  assign abs_d    = d_q[TB] ? ((TB+1)'(0) - d_q) : d_q;
  assign ival_sat = (|abs_d[TB:TB-1]) ? '1 : abs_d[TB-2:0];

  // running sum, saturating
  assign sum_ext = {1'b0, sum_q} + {1'b0, ival_q};
  assign sum_sat = sum_ext[TB-1] ? '1 : sum_ext[TB-2:0];

  // drop the rate fraction (floor) and saturate
  assign tw     = prod[PW-1:RATE_FRAC];
  assign tw_sat = ((&tw[TW-1:TB-1]) || !(|tw[TW-1:TB-1])) ? tw[TB-1:0] :
                  {tw[TW-1], {(TB-1){~tw[TW-1]}}};

  assign t_sum = {tw[TW-1], tw} + {{(TTW-TB){phase_q[TB-1]}}, phase_q};
  assign t_sat = ((&t_q[TTW-1:TB-1]) || !(|t_q[TTW-1:TB-1])) ? t_q[TB-1:0] :
                 {t_q[TTW-1], {(TB-1){~t_q[TTW-1]}}};

  assign min_t = {{(TTW-TB){min_q[TB-1]}}, min_q};
  assign max_t = {{(TTW-TB){max_q[TB-1]}}, max_q};

  assign range_full  = {max_q[TB-1], max_q} - {min_q[TB-1], min_q};
  assign range_empty = range_full[TB] || (range_full == '0);
  assign n_sub       = {{(NW-TTW){t_q[TTW-1]}}, t_q} - {{(NW-TB){min_q[TB-1]}}, min_q};
  assign nmag        = n_q[NW-1] ? (NW'(0) - n_q) : n_q;

  // below min: step the quotient down and mirror the remainder
  assign rem_nz = |div_rem;

  assign mul_a     = (state_q == S_SUM) ? {1'b0, ival_q} : local_q;
  assign mul_start = (state_q == S_SUM) || ((state_q == S_MUL_IV) && mul_stat.done);
  assign div_start = (state_q == S_NABS);

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    stamp_d   = stamp_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    local_d   = local_q;
    d_d       = d_q;
    ival_d    = ival_q;
    aival_d   = aival_q;
    t_d       = t_q;
    range_d   = range_q;
    n_d       = n_q;
    nneg_d    = nneg_q;
    r_d       = r_q;
    odd_d     = odd_q;
    anim_d    = anim_q;
    first_d   = first_q;
    active_d  = active_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (!run_q) begin
            // disabled: forget the start, report an all-zero result
            started_d = 1'b0;
            ival_d    = '0;
            aival_d   = '0;
            anim_d    = '0;
            first_d   = 1'b0;
            active_d  = 1'b0;
            state_d   = S_DONE;
          end else begin
            if (!started_q) begin
              started_d = 1'b1;
              stamp_d   = system_time_i;
              prev_d    = '0;
              sum_d     = '0;
            end
            first_d  = !started_q;
            active_d = 1'b1;
            local_d  = loc_sat;
            state_d  = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        d_d     = {local_q[TB-1], local_q} - {prev_q[TB-1], prev_q};
        prev_d  = local_q;
        state_d = S_ABS;
      end
      S_ABS: begin
        ival_d  = ival_sat;
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_d   = sum_sat;
        state_d = S_MUL_IV;
      end
      S_MUL_IV: begin
        if (mul_stat.done) begin
          aival_d = tw_sat;
          state_d = S_MUL_T;
        end
      end
      S_MUL_T: begin
        if (mul_stat.done) begin
          t_d     = t_sum;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        state_d = S_DONE;
        case (mode_q) inside
          MODE_NONE: anim_d = t_sat;
          MODE_CLAMP: begin
            if ($signed(t_q) < $signed(min_t)) begin
              anim_d = min_q;
            end else if ($signed(max_t) < $signed(t_q)) begin
              anim_d = max_q;
            end else begin
              anim_d = t_q[TB-1:0];
            end
          end
          MODE_WRAP, MODE_CYCLE: begin
            if (range_empty) begin
              anim_d = min_q;
            end else begin
              range_d = range_full[TB-1:0];
              n_d     = n_sub;
              state_d = S_NABS;
            end
          end
          default: anim_d = t_sat;
        endcase
      end
      S_NABS: begin
        nneg_d  = n_q[NW-1];
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        r_d     = (nneg_q && rem_nz) ? (range_q - div_rem) : div_rem;
        odd_d   = div_q_lsb ^ (nneg_q && rem_nz);
        state_d = S_FIN;
      end
      S_FIN: begin
        anim_d  = ((mode_q == MODE_CYCLE) && odd_q) ? (max_q - r_q) : (min_q + r_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      stamp_q   <= '0;
      prev_q    <= '0;
      sum_q     <= '0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      stamp_q   <= stamp_d;
      prev_q    <= prev_d;
      sum_q     <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    local_q  <= local_d;
    d_q      <= d_d;
    ival_q   <= ival_d;
    aival_q  <= aival_d;
    t_q      <= t_d;
    range_q  <= range_d;
    n_q      <= n_d;
    nneg_q   <= nneg_d;
    r_q      <= r_d;
    odd_q    <= odd_d;
    anim_q   <= anim_d;
    first_q  <= first_d;
    active_q <= active_d;
  end

  // ---------------------------------------------------------------------------
  // output register: hold the result until the receiver takes it
  // ---------------------------------------------------------------------------
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_anim_q   <= anim_q;
      o_ival_q   <= ival_q;
      o_aival_q  <= aival_q;
      o_sum_q    <= active_q ? sum_q : '0;
      o_first_q  <= first_q;
      o_active_q <= active_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign anim_time_o      = o_anim_q;
  assign frame_interval_o = o_ival_q;
  assign anim_interval_o  = o_aival_q;
  assign elapsed_total_o  = o_sum_q;
  assign first_frame_o    = o_first_q;
  assign active_o         = o_active_q;

  // ---------------------------------------------------------------------------
  // arithmetic units: the shared multiplier and the divider
  // ---------------------------------------------------------------------------
  atm_mul #(
    .A_BITS (TB),
    .B_BITS (RATE_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (rate_q),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  atm_div #(
    .N_BITS (NW),
    .D_BITS (TB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (nmag),
    .den_i   (range_q),
    .rem_o   (div_rem),
    .q_lsb_o (div_q_lsb),
    .stat_o  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ATM_ASSERT_NXT(a_stall_after_accept, in_accept, in_stall_o, "sample accepted while busy")
  `ATM_ASSERT_IMP(a_mul_owner, mul_stat.busy, ((state_q == S_MUL_IV) || (state_q == S_MUL_T)), "multiplier runs outside its states")
  `ATM_ASSERT_IMP(a_div_owner, div_stat.busy, (state_q == S_DIV), "divider runs outside its state")
  `ATM_ASSERT_IMP(a_inactive_zero, (out_valid_o && !active_o), ((anim_time_o == '0) && (frame_interval_o == '0) && (anim_interval_o == '0) && (elapsed_total_o == '0) && !first_frame_o), "inactive result not zero")
  `ATM_ASSERT_IMP(a_first_no_interval, (out_valid_o && first_frame_o), ((frame_interval_o == '0) && active_o), "first frame with nonzero interval")

endmodule

### src/atm_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on atm_pkg for the unit status type.
module atm_mul
  import atm_pkg::*;
#(
  parameter int A_BITS = 48,
  parameter int B_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [A_BITS-1:0]        a_i,
  input  logic [B_BITS-1:0]        b_i,
  output logic [A_BITS+B_BITS-1:0] prod_o,
  output unit_stat_t               stat_o
);

  localparam int CNT_W = $clog2(B_BITS);

  logic [A_BITS:0]   hi_q, hi_d;
  logic [B_BITS-1:0] lo_q, lo_d;
  logic [A_BITS-1:0] a_q, a_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic              last;
  logic [A_BITS+1:0] a_ext;
  logic [A_BITS+1:0] addend;
  logic [A_BITS+1:0] sum;

  assign last  = (cnt_q == CNT_W'(B_BITS - 1));
  assign a_ext = {a_q[A_BITS-1], a_q[A_BITS-1], a_q};

  always_comb begin
    // the sign bit of the multiplier weighs negative
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = (A_BITS+2)'(0) - a_ext;
    end else begin
      addend = a_ext;
    end
    sum = {hi_q[A_BITS], hi_q} + addend;
  end

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = b_i;
      a_d    = a_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[A_BITS+1:1];
      lo_d  = {sum[0], lo_q[B_BITS-1:1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    a_q  <= a_d;
  end

  assign prod_o      = {hi_q[A_BITS-1:0], lo_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### src/atm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Gives the remainder and the parity of the quotient; depends on atm_pkg.
module atm_div
  import atm_pkg::*;
#(
  parameter int N_BITS = 66,
  parameter int D_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [N_BITS-1:0] num_i,
  input  logic [D_BITS-1:0] den_i,
  output logic [D_BITS-1:0] rem_o,
  output logic              q_lsb_o,
  output unit_stat_t        stat_o
);

  localparam int CNT_W = $clog2(N_BITS);

  logic [N_BITS-1:0] num_q, num_d;
  logic [D_BITS-1:0] rem_q, rem_d;
  logic [D_BITS-1:0] den_q, den_d;
  logic              q_q, q_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic              last;
  logic [D_BITS:0]   shifted;
  logic [D_BITS+1:0] trial;
  logic              ge;

  assign last    = (cnt_q == CNT_W'(N_BITS - 1));
  assign shifted = {rem_q, num_q[N_BITS-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = ~trial[D_BITS+1];

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // keep the partial remainder below the divisor
      rem_d = ge ? trial[D_BITS-1:0] : shifted[D_BITS-1:0];
      num_d = {num_q[N_BITS-2:0], 1'b0};
      q_d   = ge;
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

  assign rem_o       = rem_q;
  assign q_lsb_o     = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### tb/tb.sv
// Self-checking testbench for animation_time_mapper: random and directed frame samples,
// checked against an in-bench model of the time mapping. Depends on atm_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atm_pkg::*;

  localparam int TW          = 48;
  localparam int CW          = (TW > RATE_BITS) ? TW : RATE_BITS;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 300;  // well past the slowest sample (wrap or cycle through the divider)
  localparam int QUIET_MIN   = 4;    // idle cycles required before a register write
  localparam int RANDOM_FRAMES = 450;

  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

  // indexes the block decodes to nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

  typedef logic signed [127:0] wide_t;

  typedef enum logic [1:0] {
    STEP_SAMPLE,
    STEP_WRITE,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e              kind;
    logic [CW-1:0]           value;
    logic [CFG_IDX_BITS-1:0] index;
  } step_t;

  typedef struct packed {
    logic [TW-1:0] anim_time;
    logic [TW-2:0] frame_interval;
    logic [TW-1:0] anim_interval;
    logic [TW-2:0] elapsed_total;
    logic          first_frame;
    logic          active;
  } frame_result_t;

  // ---------------------------------------------------------------------------
  // Clock and block I/O
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic                    in_valid    = 1'b0;
  logic [TW-1:0]           system_time = '0;
  logic                    out_stall   = 1'b0;
  logic                    cfg_valid   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index   = '0;
  logic [CW-1:0]           cfg_data    = '0;

  logic          in_stall_o;
  logic          out_valid_o;
  logic [TW-1:0] anim_time_o;
  logic [TW-2:0] frame_interval_o;
  logic [TW-1:0] anim_interval_o;
  logic [TW-2:0] elapsed_total_o;
  logic          first_frame_o;
  logic          active_o;
  logic          cfg_ready_o;

  animation_time_mapper #(
    .TIME_BITS(TW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .system_time_i   (system_time),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .anim_time_o     (anim_time_o),
    .frame_interval_o(frame_interval_o),
    .anim_interval_o (anim_interval_o),
    .elapsed_total_o (elapsed_total_o),
    .first_frame_o   (first_frame_o),
    .active_o        (active_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Model of the mapper: register copy and playback state
  // ---------------------------------------------------------------------------
  repeat_mode_e           cfg_mode   = MODE_NONE;
  logic signed [TW-1:0]   cfg_min    = '0;
  logic signed [TW-1:0]   cfg_max    = '0;
  logic signed [TW-1:0]   cfg_phase  = '0;
  logic signed [RATE_BITS-1:0] cfg_rate = RATE_ONE;
  logic                   cfg_enable = 1'b1;

  logic                   playing = 1'b0;
  logic signed [TW-1:0]   start_q = '0;
  logic signed [TW-1:0]   prev_q  = '0;
  logic [TW-2:0]          sum_q   = '0;

  step_t         stim_q[$];
  frame_result_t frames_due[$];

  int samples_queued = 0;
  int frames_sent    = 0;
  int frames_seen    = 0;
  int mismatch_count = 0;
  int hold_off       = 0;
  int quiet_cycles   = 0;
  int stall_burst    = 0;
  int cycle_count    = 0;

  // exact product with the rate, low fraction bits dropped toward minus infinity
  function automatic wide_t scale_by_rate(wide_t v);
    wide_t r;
    r = cfg_rate;
    return (v * r) >>> RATE_FRAC;
  endfunction

  function automatic logic [TW-1:0] saturate_time(wide_t v);
    wide_t top, bottom;
    top    = T_MAX;
    bottom = T_MIN;
    if (v > top) return T_MAX;
    if (v < bottom) return T_MIN;
    return v[TW-1:0];
  endfunction

  // v is never negative here
  function automatic logic [TW-2:0] saturate_mag(wide_t v);
    wide_t top;
    top = T_MAX;
    if (v > top) return '1;
    return v[TW-2:0];
  endfunction

  function automatic logic [TW-1:0] map_anim_time(wide_t lw);
    wide_t        lo, hi, ph, t, span, n;
    logic [127:0] mag, div, q, rem, mapped;
    logic         odd;
    lo = cfg_min;
    hi = cfg_max;
    ph = cfg_phase;
    t  = scale_by_rate(lw) + ph;
    if (cfg_mode == MODE_NONE) return saturate_time(t);
    if (cfg_mode == MODE_CLAMP) begin
      if (t < lo) return cfg_min;
      if (t > hi) return cfg_max;
      return t[TW-1:0];
    end
    // wrap and cycle: an empty or inverted window collapses to min
    span = hi - lo;
    if (span <= 0) return cfg_min;
    n   = t - lo;
    div = span;
    mag = (n < 0) ? -n : n;
    q   = mag / div;
    rem = mag % div;
    odd = q[0];
    // floor division for negative offsets
    if (n < 0 && rem != 0) begin
      odd = ~odd;
      rem = div - rem;
    end
    if (cfg_mode == MODE_CYCLE && odd) mapped = hi - rem;
    else mapped = lo + rem;
    return mapped[TW-1:0];
  endfunction

  // advance playback state by one sample and return the frame it should produce
  function automatic frame_result_t predict_frame(logic signed [TW-1:0] sample);
    frame_result_t        res;
    wide_t                xs, ss, ps, lw, diff, iv, acc;
    logic signed [TW-1:0] loc;
    res = '0;
    if (!cfg_enable) begin
      playing = 1'b0;
      return res;
    end
    if (!playing) begin
      start_q = sample;
      playing = 1'b1;
      prev_q  = '0;
      sum_q   = '0;
      res.first_frame = 1'b1;
    end
    xs   = sample;
    ss   = start_q;
    loc  = saturate_time(xs - ss);
    lw   = loc;
    ps   = prev_q;
    diff = lw - ps;
    if (diff < 0) diff = -diff;
    res.frame_interval = saturate_mag(diff);
    iv  = res.frame_interval;
    res.anim_interval = saturate_time(scale_by_rate(iv));
    prev_q = loc;
    acc    = sum_q;
    sum_q  = saturate_mag(acc + iv);
    res.elapsed_total = sum_q;
    res.anim_time     = map_anim_time(lw);
    res.active        = 1'b1;
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] data);
    case (idx)
      CFG_REPEAT_MODE:  cfg_mode   = repeat_mode_e'(data[1:0]);
      CFG_MIN_TIME:     cfg_min    = data[TW-1:0];
      CFG_MAX_TIME:     cfg_max    = data[TW-1:0];
      CFG_PHASE_OFFSET: cfg_phase  = data[TW-1:0];
      CFG_RATE_SCALE:   cfg_rate   = data[RATE_BITS-1:0];
      CFG_RUN_ENABLE:   cfg_enable = data[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_sample(logic [TW-1:0] v);
    stim_q.push_back('{kind: STEP_SAMPLE, value: v, index: '0});
    samples_queued++;
  endfunction

  function automatic void push_write(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] v);
    stim_q.push_back('{kind: STEP_WRITE, value: v, index: idx});
  endfunction

  function automatic void push_drain();
    stim_q.push_back('{kind: STEP_DRAIN, value: '0, index: '0});
  endfunction

  function automatic logic [TW-1:0] secs(int s);
    logic signed [TW-1:0] r;
    r = s;
    return r <<< 16;
  endfunction

  // mostly a few seconds around zero, sometimes the extremes or anything at all
  function automatic logic [TW-1:0] pick_time();
    int s;
    case ($urandom_range(0, 7))
      0: return T_MAX;
      1: return T_MIN;
      2: return {$urandom(), $urandom()};
      default: begin
        s = $urandom_range(0, 40 << 16);
        s = s - (20 << 16);
        return s;
      end
    endcase
  endfunction

  // fill the unused upper data bits with junk now and then; the block must drop them
  function automatic logic [CW-1:0] pad_reg(logic [CW-1:0] v, int w);
    logic [CW-1:0] keep, junk;
    keep = (CW'(1) << w) - 1;
    junk = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) junk = '0;
    return (v & keep) | (junk & ~keep);
  endfunction

  function automatic int draw_gap();
    if (no_idle() || $urandom_range(0, 99) >= 35) return 0;
    return $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 160);
  endfunction

  // a window in the middle of the run with neither side holding back
  function automatic bit no_idle();
    return frames_sent >= 200 && frames_sent < 290;
  endfunction

  task automatic report_mismatch(string field, logic [TW-1:0] got, logic [TW-1:0] want);
    $display("tb: mismatch on %s in frame %0d: got %h, want %h", field, frames_seen, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed samples and register writes from stim_q
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic  nxt_in, nxt_cfg;
    step_t head;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_in  = in_valid;
      nxt_cfg = cfg_valid;
      // retire the sample transaction taken at this edge and predict its frame
      if (in_valid && !in_stall_o) begin
        frames_due.push_back(predict_frame(system_time));
        frames_sent++;
        nxt_in   = 1'b0;
        hold_off = draw_gap();
      end
      if (cfg_valid && cfg_ready_o) begin
        apply_reg(cfg_index, cfg_data);
        nxt_cfg = 1'b0;
      end
      // count cycles with nothing in flight; writes and drains wait on this
      if (frames_due.size() == 0 && !nxt_in) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_in && !nxt_cfg && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.kind)
          STEP_SAMPLE: begin
            if (hold_off != 0) begin
              hold_off--;
            end else begin
              nxt_in = 1'b1;
              system_time <= head.value[TW-1:0];
              void'(stim_q.pop_front());
            end
          end
          STEP_WRITE: begin
            if (quiet_cycles >= QUIET_MIN) begin
              nxt_cfg = 1'b1;
              cfg_index <= head.index;
              cfg_data  <= head.value;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            // hold the sender until every frame has come back
            if (quiet_cycles >= QUIET_MIN) void'(stim_q.pop_front());
          end
        endcase
      end
      in_valid  <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // Receiver back-pressure: random stalls, rare long bursts, none in the quiet window
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (no_idle()) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      stall_burst = $urandom_range(20, 300);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every frame taken against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (frames_due.size() == 0) begin
        report_mismatch("unexpected frame", anim_time_o, '0);
      end else begin
        want = frames_due.pop_front();
        if (anim_time_o !== want.anim_time)
          report_mismatch("anim_time", anim_time_o, want.anim_time);
        if (frame_interval_o !== want.frame_interval)
          report_mismatch("frame_interval", frame_interval_o, want.frame_interval);
        if (anim_interval_o !== want.anim_interval)
          report_mismatch("anim_interval", anim_interval_o, want.anim_interval);
        if (elapsed_total_o !== want.elapsed_total)
          report_mismatch("elapsed_total", elapsed_total_o, want.elapsed_total);
        if (first_frame_o !== want.first_frame)
          report_mismatch("first_frame", first_frame_o, want.first_frame);
        if (active_o !== want.active)
          report_mismatch("active", active_o, want.active);
      end
      frames_seen++;
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed corners first, then random phases of register settings
  // ---------------------------------------------------------------------------
  initial begin
    logic [TW-1:0]        lo_v, hi_v, t_v;
    logic [RATE_BITS-1:0] rate_v;
    logic [1:0]           mode_v;
    int                   n_frames, pick;

    // defaults after reset: mode none, rate 1.0, enabled
    push_sample(secs(0));            // latch start at zero
    push_sample(48'd1092);           // one 60 Hz frame later
    push_sample(T_MAX);
    push_sample(T_MIN);              // interval and running sum saturate
    push_write(CFG_RUN_ENABLE, '0);
    push_sample(secs(5));            // inactive frame, drops playback
    push_write(CFG_RUN_ENABLE, 1);
    push_sample(T_MIN);              // restart at the most negative time
    push_sample(T_MAX);              // local time saturates
    push_write(CFG_RUN_ENABLE, '0);
    push_sample(T_MAX);
    push_write(CFG_RUN_ENABLE, 1);
    push_sample(secs(0));            // restart at zero
    push_write(CFG_RATE_SCALE, 48'h7FFF_FFFF);
    push_sample(48'h100_0000_0000);  // scaled interval and time saturate high
    push_write(CFG_RATE_SCALE, 48'h8000_0000);
    push_sample(secs(0));            // scaled interval saturates low
    push_sample(T_MAX);
    push_write(CFG_RATE_SCALE, RATE_ONE);
    push_write(CFG_REPEAT_MODE, MODE_CLAMP);
    push_write(CFG_MIN_TIME, secs(10));
    push_write(CFG_MAX_TIME, secs(20));
    push_sample(secs(5));
    push_sample(secs(15));
    push_sample(secs(25));
    // clamp with min above max
    push_write(CFG_MIN_TIME, secs(20));
    push_write(CFG_MAX_TIME, secs(10));
    push_sample(secs(15));
    push_sample(secs(25));
    push_write(CFG_REPEAT_MODE, MODE_WRAP);
    push_write(CFG_MIN_TIME, secs(-3));
    push_write(CFG_MAX_TIME, secs(5));
    push_sample(secs(-7));           // below min: floor quotient, nonzero remainder
    push_sample(secs(12));
    push_write(CFG_REPEAT_MODE, MODE_CYCLE);
    push_sample(secs(12));           // odd lap runs backward
    push_sample(secs(-7));
    push_sample(secs(5));            // lands exactly on max
    push_write(CFG_MAX_TIME, secs(-3));  // empty window
    push_sample(secs(3));
    push_write(CFG_REPEAT_MODE, MODE_NONE);
    push_write(CFG_PHASE_OFFSET, T_MAX);
    push_sample(secs(1));
    push_write(CFG_PHASE_OFFSET, T_MIN);
    push_sample(secs(-1));

    while (samples_queued < RANDOM_FRAMES) begin
      // half the phases restart playback so local time starts small
      if ($urandom_range(0, 1) != 0) begin
        push_write(CFG_RUN_ENABLE, pad_reg('0, 1));
        push_sample(pick_time());
      end
      mode_v = 2'($urandom_range(0, 3));
      lo_v   = pick_time();
      case ($urandom_range(0, 5))
        0: hi_v = lo_v;
        1: hi_v = pick_time();
        2: hi_v = lo_v - $urandom_range(1, 1 << 20);
        default: hi_v = lo_v + $urandom_range(1, 10 << 16);
      endcase
      case ($urandom_range(0, 9))
        0: rate_v = 32'h7FFF_FFFF;
        1: rate_v = 32'h8000_0000;
        2: rate_v = $urandom();
        3: rate_v = '0;
        4: rate_v = RATE_ONE;
        default: rate_v = $urandom_range(0, 8 << 16) - (4 << 16);
      endcase
      push_write(CFG_REPEAT_MODE, pad_reg(mode_v, 2));
      push_write(CFG_MIN_TIME, lo_v);
      push_write(CFG_MAX_TIME, hi_v);
      push_write(CFG_PHASE_OFFSET, ($urandom_range(0, 2) == 0) ? pick_time() : '0);
      push_write(CFG_RATE_SCALE, pad_reg(rate_v, RATE_BITS));
      if ($urandom_range(0, 5) == 0)
        push_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom(), $urandom()});
      push_write(CFG_RUN_ENABLE, pad_reg(($urandom_range(0, 9) != 0), 1));

      // mostly steady frame times, with backward steps, jumps and raw noise
      t_v      = pick_time();
      n_frames = $urandom_range(6, 30);
      repeat (n_frames) begin
        pick = $urandom_range(0, 99);
        if (pick < 84) t_v = t_v + $urandom_range(0, 3000);
        else if (pick < 89) t_v = t_v - $urandom_range(0, 1 << 20);
        else if (pick < 94) t_v = t_v + ({$urandom(), $urandom()} >> $urandom_range(8, 40));
        else if (pick < 98) t_v = {$urandom(), $urandom()};
        else t_v = $urandom_range(0, 1) ? T_MAX : T_MIN;
        push_sample(t_v);
        if ($urandom_range(0, 39) == 0) begin
          // pause playback for one frame mid-phase
          push_write(CFG_RUN_ENABLE, '0);
          push_sample(t_v);
          push_write(CFG_RUN_ENABLE, 1);
        end else if ($urandom_range(0, 39) == 0) begin
          push_drain();
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every transaction to go out and every frame to come back
    while (stim_q.size() != 0 || in_valid || cfg_valid || frames_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && frames_due.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

### animation_time_mapper.f
+incdir+src
src/atm_pkg.sv
src/atm_mul.sv
src/atm_div.sv
src/animation_time_mapper.sv
tb/tb.sv
